FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion wrappers for the strided view bounds checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: design/svbc_pkg.sv
// ---------------------------------------------------------------------------
// svbc_pkg
// Types, codes and helpers shared by the strided view bounds checker.
// ---------------------------------------------------------------------------
package svbc_pkg;

    // Default rank limit; views with more dimensions report a rank error.
    localparam int MAX_RANK_DEF = 32;
    localparam logic [6:0] DIMS_SAT = 7'd127;

    // Configuration register indexes
    localparam logic [2:0] CFG_ELEM_SIZE_LOG2   = 3'd0;
    localparam logic [2:0] CFG_VIEW_OFFSET      = 3'd1;
    localparam logic [2:0] CFG_HAS_STORAGE      = 3'd2;
    localparam logic [2:0] CFG_STORAGE_HAS_DATA = 3'd3;
    localparam logic [2:0] CFG_STORAGE_BYTES    = 3'd4;

    // Result status codes, lowest number wins; stride and overflow go by the earliest faulty dimension
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_RANK      = 3'd1;
    localparam logic [2:0] STATUS_SHAPE     = 3'd2;
    localparam logic [2:0] STATUS_UNALIGNED = 3'd3;
    localparam logic [2:0] STATUS_STRIDE    = 3'd4;
    localparam logic [2:0] STATUS_OVERFLOW  = 3'd5;
    localparam logic [2:0] STATUS_EXCEEDS   = 3'd6;

    typedef struct packed {
        logic signed [63:0] dim_extent;
        logic signed [63:0] dim_stride;
        logic               carries_dim;
        logic               last;
    } svbc_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] end_offset;
        logic [62:0] element_count;
    } svbc_out_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       mul_step;
        logic [1:0] step_idx;
        logic       update;
        logic       load_out;
    } svbc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic item_last;
    } svbc_sts_t;

    // Low-bit mask of an element-size alignment check
    function automatic logic [2:0] align_mask(input logic [1:0] esl);
        logic [2:0] m;
        unique case (esl)
            2'd0: m = 3'b000;
            2'd1: m = 3'b001;
            2'd2: m = 3'b011;
            2'd3: m = 3'b111;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    // Element size in bytes
    function automatic logic [3:0] elem_bytes(input logic [1:0] esl);
        return 4'b0001 << esl;
    endfunction

endpackage

FILE: design/svbc_ctrl.sv
// ---------------------------------------------------------------------------
// svbc_ctrl
// Sequencer for the bounds checker: item intake, multiply steps, result load.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module svbc_ctrl
    import svbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      in_carries,
    input  logic      in_last,
    output logic      m_valid,
    input  logic      m_ready,
    output svbc_cmd_t cmd,
    input  svbc_sts_t sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.step_idx = step_reg;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    step_next   = 2'd0;
                    if (in_carries) begin
                        state_next = ST_MUL;
                    end else if (in_last) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                step_next    = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = sts.item_last ? ST_FIN : ST_IDLE;
            end
            ST_FIN: begin
                // hold until the output slot is free
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    `ASSERT_NEXT(a_mul_to_upd, aclk, aresetn, state_reg == ST_MUL && step_reg == 2'd3, state_reg == ST_UPD)
    `ASSERT_NEXT(a_dim_item_to_mul, aclk, aresetn, s_valid && s_ready && in_carries, state_reg == ST_MUL && step_reg == 2'd0)
    `ASSERT_IMPLIES(a_load_slot_free, aclk, aresetn, cmd.load_out, !out_valid_reg || m_ready)
    `ASSERT_IMPLIES(a_out_drop_on_transfer, aclk, aresetn, $fell(out_valid_reg), $past(m_ready))

endmodule

FILE: design/svbc_dp.sv
// ---------------------------------------------------------------------------
// svbc_dp
// Datapath: config registers, descriptor state, two stepped 32x32 multipliers.
// ---------------------------------------------------------------------------
module svbc_dp
    import svbc_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  svbc_in_t    s_payload,
    input  svbc_cmd_t   cmd,
    output svbc_sts_t   sts,
    output svbc_out_t   m_payload
);

    // configuration
    logic [1:0]  esl_reg;
    logic [63:0] vo_reg;
    logic        hs_reg;
    logic        shd_reg;
    logic [63:0] sb_reg;

    // current item
    logic [63:0] ext_reg;
    logic [63:0] str_reg;
    logic [63:0] span_reg;
    logic        last_reg;

    // descriptor state
    logic [6:0]  dims_reg;
    logic [62:0] cp_reg;
    logic [63:0] end_reg;
    logic        shape_bad_reg;
    logic [2:0]  fde_reg;

    // product accumulators
    logic [127:0] acc_a_reg;
    logic [127:0] acc_b_reg;

    svbc_out_t   out_reg;

    logic [31:0]  a_lo, a_hi, b_lo, b_hi;
    logic [63:0]  pp_a, pp_b;
    logic [127:0] pp_a_sh, pp_b_sh;
    logic [1:0]   shift_sel;
    logic [63:0]  end_eff;
    logic [63:0]  span_in;
    logic         ovf_a, ovf_b, str_bad;
    logic [63:0]  size64, room;
    logic         storage_bad;
    logic [2:0]   status_fin;

    function automatic logic [31:0] step_a_half(input logic hi, input logic [63:0] v);
        return hi ? v[63:32] : v[31:0];
    endfunction

    always_comb begin
        a_lo = step_a_half(cmd.step_idx[0], {1'b0, cp_reg});
        b_lo = step_a_half(cmd.step_idx[1], {1'b0, ext_reg[62:0]});
        a_hi = step_a_half(cmd.step_idx[0], span_reg);
        b_hi = step_a_half(cmd.step_idx[1], str_reg);
        pp_a = {32'd0, a_lo} * {32'd0, b_lo};
        pp_b = {32'd0, a_hi} * {32'd0, b_hi};
        shift_sel = {1'b0, cmd.step_idx[0]} + {1'b0, cmd.step_idx[1]};
        unique case (shift_sel)
            2'd0: begin
                pp_a_sh = {64'd0, pp_a};
                pp_b_sh = {64'd0, pp_b};
            end
            2'd1: begin
                pp_a_sh = {32'd0, pp_a, 32'd0};
                pp_b_sh = {32'd0, pp_b, 32'd0};
            end
            default: begin
                pp_a_sh = {pp_a, 64'd0};
                pp_b_sh = {pp_b, 64'd0};
            end
        endcase
    end

    // the offset enters the end accumulator at the first dimension
    assign end_eff = (dims_reg == 7'd0) ? vo_reg : end_reg;
    assign span_in = (s_payload.dim_extent != 64'sd0) ?
                     (64'(s_payload.dim_extent) - 64'd1) : 64'd0;

    assign ovf_a   = |acc_a_reg[127:63];
    assign ovf_b   = |acc_b_reg[127:64];
    assign str_bad = str_reg[63] || ((str_reg[2:0] & align_mask(esl_reg)) != 3'd0);

    assign size64 = {60'd0, elem_bytes(esl_reg)};
    assign room   = sb_reg - end_eff;
    assign storage_bad = hs_reg && ((vo_reg > sb_reg) ||
                         ((cp_reg != 63'd0) &&
                          (!shd_reg || (end_eff > sb_reg) || (size64 > room))));

    always_comb begin
        priority if (dims_reg > 7'(MAX_RANK)) begin
            status_fin = STATUS_RANK;
        end else if (shape_bad_reg) begin
            status_fin = STATUS_SHAPE;
        end else if ((vo_reg[2:0] & align_mask(esl_reg)) != 3'd0) begin
            status_fin = STATUS_UNALIGNED;
        end else if (fde_reg != STATUS_OK) begin
            status_fin = fde_reg;
        end else if (storage_bad) begin
            status_fin = STATUS_EXCEEDS;
        end else begin
            status_fin = STATUS_OK;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esl_reg <= 2'd0;
            vo_reg  <= 64'd0;
            hs_reg  <= 1'b0;
            shd_reg <= 1'b0;
            sb_reg  <= 64'd0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ELEM_SIZE_LOG2:   esl_reg <= cfg_data[1:0];
                CFG_VIEW_OFFSET:      vo_reg  <= cfg_data;
                CFG_HAS_STORAGE:      hs_reg  <= cfg_data[0];
                CFG_STORAGE_HAS_DATA: shd_reg <= cfg_data[0];
                CFG_STORAGE_BYTES:    sb_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture and multiply accumulation
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ext_reg   <= 64'(s_payload.dim_extent);
            str_reg   <= 64'(s_payload.dim_stride);
            span_reg  <= span_in;
            last_reg  <= s_payload.last;
            acc_a_reg <= 128'd0;
            acc_b_reg <= {64'd0, end_eff};
        end else if (cmd.mul_step) begin
            acc_a_reg <= acc_a_reg + pp_a_sh;
            acc_b_reg <= acc_b_reg + pp_b_sh;
        end
    end

    // descriptor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg      <= 7'd0;
            cp_reg        <= 63'd1;
            end_reg       <= 64'd0;
            shape_bad_reg <= 1'b0;
            fde_reg       <= STATUS_OK;
        end else if (cmd.load_out) begin
            dims_reg      <= 7'd0;
            cp_reg        <= 63'd1;
            end_reg       <= 64'd0;
            shape_bad_reg <= 1'b0;
            fde_reg       <= STATUS_OK;
        end else if (cmd.update) begin
            if (dims_reg < DIMS_SAT) begin
                dims_reg <= dims_reg + 7'd1;
            end
            if (!shape_bad_reg) begin
                if (ext_reg[63] || ovf_a) begin
                    shape_bad_reg <= 1'b1;
                end else begin
                    cp_reg <= acc_a_reg[62:0];
                end
            end
            // advance the end only while no dimension has failed
            if ((fde_reg == STATUS_OK) && !str_bad && !ovf_b) begin
                end_reg <= acc_b_reg[63:0];
            end else begin
                end_reg <= end_eff;
            end
            if (fde_reg == STATUS_OK) begin
                if (str_bad) begin
                    fde_reg <= STATUS_STRIDE;
                end else if (ovf_b) begin
                    fde_reg <= STATUS_OVERFLOW;
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg.status        <= status_fin;
            out_reg.end_offset    <= (status_fin == STATUS_OK) ? end_eff : 64'd0;
            out_reg.element_count <= (status_fin == STATUS_OK) ? cp_reg : 63'd0;
        end
    end

    assign sts.item_last = last_reg;
    assign m_payload     = out_reg;

endmodule

FILE: design/strided_view_bounds_check.sv
// ---------------------------------------------------------------------------
// strided_view_bounds_check
// Validates a strided tensor view descriptor against its backing storage.
// ---------------------------------------------------------------------------
// Feed one transfer per dimension (extent, byte stride), the final one with
// last set; a rank-0 view is a single transfer with carries_dim clear and
// last set. Each descriptor yields exactly one result transfer with a status,
// the byte offset of the last element and the element count (both zero on
// any failing status). A dimension transfer occupies the block through an
// intake step, four steps of the two 32x32 multipliers (element count
// product and stride span times stride, each checked for overflow), and a
// state update. The closing transfer then loads the result register, once
// no earlier result still waits on m_ready; a transfer without a dimension
// is only taken in, and one that closes the view goes on to that load.
// Transfers without a dimension and without last are dropped. Write the
// configuration registers (element size, view offset, storage flags, storage
// size) only while no descriptor is in flight; the port always accepts.
// ---------------------------------------------------------------------------
module strided_view_bounds_check
    import svbc_pkg::*;
#(
    parameter int MAX_RANK = MAX_RANK_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  svbc_in_t    s_payload,

    output logic        m_valid,
    input  logic        m_ready,
    output svbc_out_t   m_payload,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    svbc_cmd_t cmd;
    svbc_sts_t sts;

    // configuration writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: intake, multiply steps, update, result load
    svbc_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .in_carries (s_payload.carries_dim),
        .in_last    (s_payload.last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    // registers, multipliers and status evaluation
    svbc_dp #(
        .MAX_RANK (MAX_RANK)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_payload (s_payload),
        .cmd       (cmd),
        .sts       (sts),
        .m_payload (m_payload)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the strided view bounds checker. Streams view
// descriptors (one transfer per dimension, closed by a last transfer) through
// the valid/ready input, predicts each status, end offset and element count
// in a scoreboard, and compares every result transfer against the oldest
// prediction. Registers are reprogrammed between phases while the block idles.
// ---------------------------------------------------------------------------
module tb_top;
    import svbc_pkg::*;

    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] U64_ALL = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int          ITEM_TARGET    = 1350;
    localparam int          PHASES         = 8;
    // A dimension holds the block through intake, multiply steps and update, plus the result load.
    localparam int          SETTLE_CYCLES  = 16;
    localparam int          WATCHDOG_LIMIT = 4000;

    // -----------------------------------------------------------------------
    // Scoreboard: mirrors the register file and the per-view accumulators,
    // and keeps the verdicts still owed by the block in arrival order.
    // -----------------------------------------------------------------------
    class view_verdict_board;
        logic [1:0]  elem_log2;
        logic [63:0] base_offset;
        logic        backed;
        logic        backed_has_data;
        logic [63:0] backing_bytes;

        logic [6:0]  dim_count;
        logic [63:0] extent_product;
        logic [63:0] far_end;
        logic        shape_broken;
        logic [2:0]  dim_fault;

        svbc_out_t   verdicts_due[$];
        int unsigned mismatches;

        function new();
            elem_log2       = '0;
            base_offset     = '0;
            backed          = 1'b0;
            backed_has_data = 1'b0;
            backing_bytes   = '0;
            mismatches      = 0;
            clear_view();
        endfunction

        function void clear_view();
            dim_count      = '0;
            extent_product = 64'd1;
            far_end        = '0;
            shape_broken   = 1'b0;
            dim_fault      = STATUS_OK;
        endfunction

        function void note_register(logic [2:0] idx, logic [63:0] val);
            case (idx)
                CFG_ELEM_SIZE_LOG2:   elem_log2       = val[1:0];
                CFG_VIEW_OFFSET:      base_offset     = val;
                CFG_HAS_STORAGE:      backed          = val[0];
                CFG_STORAGE_HAS_DATA: backed_has_data = val[0];
                CFG_STORAGE_BYTES:    backing_bytes   = val;
                default: ;
            endcase
        endfunction

        // Fold one dimension into the element count and the farthest byte.
        function void fold_dimension(logic [63:0] ext, logic [63:0] str);
            logic [63:0] esize;
            logic [63:0] span;
            esize = 64'd1 << elem_log2;
            if (dim_count == 0) far_end = base_offset;
            if (dim_count != DIMS_SAT) dim_count = dim_count + 7'd1;

            if (!shape_broken) begin
                if (ext[63] || (ext != 0 && extent_product > I64_MAX / ext))
                    shape_broken = 1'b1;
                else
                    extent_product = (extent_product * ext) & I64_MAX;
            end

            // Only the earliest faulty dimension counts; later ones leave far_end.
            if (dim_fault == STATUS_OK) begin
                if (str[63] || (str & (esize - 64'd1)) != 0) begin
                    dim_fault = STATUS_STRIDE;
                end else begin
                    span = (ext != 0) ? ext - 64'd1 : 64'd0;
                    if (span != 0 && str > (U64_ALL - far_end) / span)
                        dim_fault = STATUS_OVERFLOW;
                    else
                        far_end = far_end + span * str;
                end
            end
        endfunction

        function void note_transfer(svbc_in_t it);
            logic [63:0] esize;
            logic [63:0] fin;
            logic [2:0]  st;
            svbc_out_t   v;
            if (it.carries_dim) fold_dimension(it.dim_extent, it.dim_stride);
            if (!it.last) return;

            esize = 64'd1 << elem_log2;
            fin   = (dim_count == 0) ? base_offset : far_end;
            if (dim_count > MAX_RANK_DEF)
                st = STATUS_RANK;
            else if (shape_broken)
                st = STATUS_SHAPE;
            else if ((base_offset & (esize - 64'd1)) != 0)
                st = STATUS_UNALIGNED;
            else if (dim_fault != STATUS_OK)
                st = dim_fault;
            else if (backed && (base_offset > backing_bytes ||
                     (extent_product != 0 && (!backed_has_data ||
                      fin > backing_bytes || esize > backing_bytes - fin))))
                st = STATUS_EXCEEDS;
            else
                st = STATUS_OK;

            v.status        = st;
            v.end_offset    = (st == STATUS_OK) ? fin : 64'd0;
            v.element_count = (st == STATUS_OK) ? extent_product[62:0] : 63'd0;
            verdicts_due = {verdicts_due, v};
            clear_view();
        endfunction

        function void check_verdict(svbc_out_t got);
            svbc_out_t want;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result transfer with no view pending: ",
                              "status %0d end %h count %h"},
                             $time, got.status, got.end_offset, got.element_count);
                return;
            end
            want = verdicts_due.pop_front();
            if (got.status !== want.status || got.end_offset !== want.end_offset ||
                got.element_count !== want.element_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch status exp %0d got %0d, end exp %h got %h, ",
                              "count exp %h got %h"}, $time, want.status, got.status,
                             want.end_offset, got.end_offset,
                             want.element_count, got.element_count);
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and DUT
    // -----------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    svbc_in_t    s_payload = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    svbc_out_t   m_payload;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    view_verdict_board board;
    logic [1:0]        cur_esl      = '0;  // element size the stimulus aligns to
    logic              idle_on      = 1'b1; // random stalls allowed on both sides
    int                sent_items   = 0;
    int                stall_left   = 0;
    int                quiet_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    strided_view_bounds_check DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // -----------------------------------------------------------------------
    // Monitor: every input is driven by NBA at the edge, so the values seen
    // here are the pre-edge ones the DUT samples. Check results before noting
    // the same edge's input so a stray result never pairs with a new view.
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_verdict(m_payload);
            if (cfg_valid && cfg_ready) board.note_register(cfg_index, cfg_data);
            if (s_valid && s_ready) board.note_transfer(s_payload);
        end
    end

    // Result side backpressure: random stall bursts while idle_on is set.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: trip when no transfer on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[strided_view_bounds_check] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Corner-heavy 64-bit value for noise dimensions.
    function automatic logic [63:0] corner64();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2: return U64_ALL;
            3: return I64_MIN;
            4: return I64_MAX;
            5: return rand64();
            6: return rand64() >> $urandom_range(0, 63);
            default: return 64'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic svbc_in_t dim_item(logic [63:0] ext, logic [63:0] str,
                                          logic closes);
        svbc_in_t it;
        it.dim_extent  = ext;
        it.dim_stride  = str;
        it.carries_dim = 1'b1;
        it.last        = closes;
        return it;
    endfunction

    // Transfer without a dimension: closes a view, or is dropped by the block.
    function automatic svbc_in_t bare_item(logic closes);
        svbc_in_t it;
        it.dim_extent  = rand64();
        it.dim_stride  = rand64();
        it.carries_dim = 1'b0;
        it.last        = closes;
        return it;
    endfunction

    task automatic hold_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Present one transfer and hold it until accepted; valid stays high after
    // the accepting edge unless an idle burst drops it.
    task automatic push_item(svbc_in_t it);
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        if (it.carries_dim || it.last) sent_items++;
        if (idle_on && $urandom_range(0, 4) == 0) hold_sender($urandom_range(1, 5));
    endtask

    // Hold off the sender until every verdict has arrived and the block is idle.
    task automatic drain_views();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(logic [2:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_regs(logic [1:0] esl, logic [63:0] off, logic has,
                                logic dat, logic [63:0] bytes);
        put_reg(CFG_ELEM_SIZE_LOG2, 64'(esl));
        put_reg(CFG_VIEW_OFFSET, off);
        put_reg(CFG_HAS_STORAGE, 64'(has));
        put_reg(CFG_STORAGE_HAS_DATA, 64'(dat));
        put_reg(CFG_STORAGE_BYTES, bytes);
        cfg_valid <= 1'b0;
        cur_esl = esl;
    endtask

    // Mostly aligned offsets with storage sized near the views, plus extremes.
    task automatic random_regs();
        logic [1:0]  esl;
        logic [63:0] off;
        logic [63:0] bytes;
        esl = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
            0: off = 64'd0;
            1: off = rand64();
            2: off = U64_ALL - 64'($urandom_range(0, 4096));
            3: off = 64'($urandom_range(1, 4096));
            default: off = 64'($urandom_range(0, 512)) << esl;
        endcase
        case ($urandom_range(0, 7))
            0: bytes = 64'd0;
            1: bytes = U64_ALL;
            2: bytes = rand64();
            default: bytes = off + 64'($urandom_range(0, 12000));
        endcase
        program_regs(esl, off, $urandom_range(0, 3) != 0, $urandom_range(0, 5) != 0, bytes);
    endtask

    // View of unit dimensions, used to push the rank past the limit.
    task automatic long_view(int rank);
        for (int d = 0; d < rank; d++)
            push_item(dim_item(64'd1, 64'd0, d == rank - 1));
    endtask

    task automatic random_view();
        int          kind;
        int          rank;
        int          bad_dim;
        logic        closed;
        logic [63:0] ext;
        logic [63:0] str;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            push_item(bare_item(1'b1));  // rank-0 view
            return;
        end
        if (kind < 10) begin
            push_item(bare_item(1'b0));  // dropped by the block
            return;
        end
        rank    = (kind >= 90) ? $urandom_range(30, 36) : $urandom_range(1, 4);
        bad_dim = $urandom_range(0, rank - 1);
        closed  = 1'b0;
        for (int d = 0; d < rank; d++) begin
            ext = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'($urandom_range(1, 9));
            str = 64'($urandom_range(0, 64)) << cur_esl;
            if (kind >= 70 && kind < 78) begin
                ext = corner64();
                str = corner64();
            end else if (kind >= 78 && kind < 85 && d == bad_dim) begin
                // break one dimension of an otherwise clean view
                case ($urandom_range(0, 3))
                    0: ext = -64'($urandom_range(1, 5));
                    1: str = (cur_esl != 0) ? (str | 64'd1) : -64'($urandom_range(1, 9));
                    2: begin
                        ext = 64'($urandom_range(2, 9));
                        str = 64'h0100_0000_0000_0000 << $urandom_range(0, 6);
                    end
                    default: ext = 64'd1 << $urandom_range(31, 62);
                endcase
            end else if (kind >= 85 && kind < 90) begin
                ext = (64'd1 << $urandom_range(10, 40)) + 64'($urandom);
            end else if (kind >= 90) begin
                ext = 64'($urandom_range(1, 2));
            end
            closed = (d == rank - 1) && ($urandom_range(0, 7) != 0);
            push_item(dim_item(ext, str, closed));
            if (!closed && $urandom_range(0, 15) == 0) push_item(bare_item(1'b0));
        end
        if (!closed) push_item(bare_item(1'b1));
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: no storage, byte elements.
        program_regs(2'd0, 64'd0, 1'b0, 1'b0, 64'd0);
        push_item(bare_item(1'b1));                              // rank-0 view
        push_item(bare_item(1'b0));                              // dropped transfer
        push_item(dim_item(64'd3, 64'd5, 1'b0));
        push_item(dim_item(64'd4, 64'd100, 1'b1));               // clean 2-D view
        push_item(dim_item(I64_MAX, 64'd1, 1'b1));               // largest extent
        push_item(dim_item(I64_MIN, I64_MIN, 1'b1));             // negative shape
        push_item(dim_item(64'd1 << 40, 64'd8, 1'b0));
        push_item(dim_item(64'd1 << 30, 64'd8, 1'b1));           // count overflow
        push_item(dim_item(64'd0, U64_ALL, 1'b1));               // negative stride
        push_item(dim_item(64'd3, I64_MAX, 1'b0));
        push_item(dim_item(64'd3, I64_MAX, 1'b1));               // layout overflow
        push_item(dim_item(U64_ALL, 64'd1, 1'b1));               // extent of -1

        // Directed: 8-byte elements checked against a 4 KiB buffer.
        drain_views();
        program_regs(2'd3, 64'd8, 1'b1, 1'b1, 64'd4096);
        push_item(dim_item(64'd4, 64'd16, 1'b0));
        push_item(dim_item(64'd8, 64'd512, 1'b1));               // fits
        push_item(dim_item(64'd4, 64'd16, 1'b0));
        push_item(dim_item(64'd9, 64'd512, 1'b1));               // runs past the end
        push_item(dim_item(64'd2, 64'd12, 1'b1));                // unaligned stride
        push_item(dim_item(64'd0, 64'd8, 1'b1));                 // empty view
        push_item(dim_item(64'd5, 64'd8, 1'b0));
        push_item(bare_item(1'b1));                              // closed without dim

        // Directed: unaligned view offset.
        drain_views();
        program_regs(2'd2, 64'd6, 1'b1, 1'b0, U64_ALL);
        push_item(dim_item(64'd2, 64'd4, 1'b1));

        // Directed: offset at the top of the address space, storage without data.
        drain_views();
        program_regs(2'd2, U64_ALL - 64'd3, 1'b1, 1'b0, U64_ALL);
        push_item(bare_item(1'b1));
        push_item(dim_item(64'd1, 64'd4, 1'b1));
        push_item(dim_item(64'd2, 64'd4, 1'b1));                 // wraps the address

        // Random phases, each with its own register setting; the last runs
        // with no stalls on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_views();
            if (phase == 0)
                program_regs(2'd3, U64_ALL & ~64'd7, 1'b1, 1'b1, U64_ALL);
            else if (phase == 1)
                program_regs(2'd0, 64'd0, 1'b0, 1'b0, 64'd0);
            else
                random_regs();
            idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (phase == 1) begin
                long_view(130);  // saturates the dimension counter
                long_view(33);
            end
            while (sent_items < ITEM_TARGET * (phase + 1) / PHASES) begin
                random_view();
                if ($urandom_range(0, 39) == 0) drain_views();
            end
        end

        drain_views();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("[strided_view_bounds_check] OK");
        else
            $display("[strided_view_bounds_check] ERROR");
        $finish;
    end

endmodule
